>>> sv/shgc_pkg.sv
// shgc_pkg: types and constants for the semispace heap copying collector.
// No dependencies; used by semispace_heap_copying_collector_unit.
`timescale 1ns / 1ps

package shgc_pkg;

    localparam logic [3:0] OP_UNTRACED = 4'd0;
    localparam logic [3:0] OP_TAGGED   = 4'd1;
    localparam logic [3:0] OP_ARRAY    = 4'd2;
    localparam logic [3:0] OP_STRING   = 4'd3;
    localparam logic [3:0] OP_HEAP_RD  = 4'd4;
    localparam logic [3:0] OP_HEAP_WR  = 4'd5;
    localparam logic [3:0] OP_ROOT_RD  = 4'd6;
    localparam logic [3:0] OP_ROOT_WR  = 4'd7;
    localparam logic [3:0] OP_HDL_WR   = 4'd8;
    localparam logic [3:0] OP_HDL_RD   = 4'd9;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_OOM     = 2'd1;
    localparam logic [1:0] STAT_CORRUPT = 2'd2;

    localparam logic [31:0] FWD_BIT    = 32'h8000_0000;
    localparam logic [31:0] LEN_MASK   = 32'h1fff_ffff;
    localparam logic [31:0] TAG_MASK   = 32'h6000_0000;
    localparam logic [31:0] TAG_TAGGED = 32'h2000_0000;
    localparam logic [31:0] TAG_TRACED = 32'h4000_0000;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_HRD, S_RRD, S_DONE,
        A_FIT, A_FILL,
        G_START, G_ROOT, G_ROOTW, G_SCAN, G_SHDR, G_FLD, G_FLDW, G_SWAP,
        E_CHK, E_HDR, E_FWDR, E_SIZE, E_CPRD, E_CPWR, E_FWD1, E_FWD2, E_RET
    } state_t;

    typedef enum logic [1:0] {
        CTX_HANDLER, CTX_ROOT, CTX_FIELD
    } ctx_t;

endpackage

>>> sv/shgc_ram.sv
// shgc_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module shgc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/semispace_heap_copying_collector_unit.sv
// semispace_heap_copying_collector_unit: semispace heap, root store and Cheney collector.
// Depends on shgc_pkg and shgc_ram.
//
//   channel | handshake            | payload
//   req     | req_valid, req_stall | op, value, node, offset, root_index, live_roots
//   rsp     | rsp_valid, rsp_stall | result_value, status, collected
//
// A collection visits each live root and each scanned field, reads each scanned node header,
// and copies each node it reaches word by word or follows its forwarding word; the heap is
// served by a single heap RAM port pair. After reset the root store is cleared, one slot a
// cycle. req_stall is high while a transaction is in work; a result waits in the
// output register while rsp_stall is high.
`timescale 1ns / 1ps

module semispace_heap_copying_collector_unit #(
    parameter int HEAP_WORDS = 4096,
    parameter int ROOT_SLOTS = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [3:0]  op,
    input  logic [31:0] value,
    input  logic [13:0] node,
    input  logic [12:0] offset,
    input  logic [10:0] root_index,
    input  logic [11:0] live_roots,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] result_value,
    output logic [1:0]  status,
    output logic        collected
);

    localparam int SA_W = $clog2(2 * HEAP_WORDS);
    localparam int AI_W = $clog2(HEAP_WORDS + 1);
    localparam int RS_W = ROOT_SLOTS > 1 ? $clog2(ROOT_SLOTS) : 1;
    localparam logic [31:0] H32 = 32'(HEAP_WORDS);
    localparam logic [31:0] STORE32 = 32'(2 * HEAP_WORDS);
    localparam logic [12:0] RS13 = 13'(ROOT_SLOTS);

    shgc_pkg::state_t state_reg, state_next;
    shgc_pkg::ctx_t   ctx_reg, ctx_next;

    logic            out_valid_reg, out_valid_next;
    logic [31:0]     out_val_reg, out_val_next;
    logic [1:0]      out_st_reg, out_st_next;
    logic            out_col_reg, out_col_next;
    logic [31:0]     rs_val_reg, rs_val_next;
    logic [1:0]      rs_st_reg, rs_st_next;
    logic            gc_done_reg, gc_done_next;
    logic            half_reg, half_next;
    logic [AI_W-1:0] alloc_reg, alloc_next;
    logic [AI_W-1:0] copy_reg, copy_next;
    logic [AI_W-1:0] scan_reg, scan_next;
    logic [31:0]     handler_reg, handler_next;
    logic [12:0]     ri_reg, ri_next;
    logic [3:0]      op_reg, op_next;
    logic [31:0]     value_reg, value_next;
    logic [12:0]     live_reg, live_next;
    logic [33:0]     size_reg, size_next;
    logic [AI_W-1:0] k_reg, k_next;
    logic [SA_W-1:0] p_reg, p_next;
    logic [31:0]     ptr_reg, ptr_next;
    logic [31:0]     ev_idx_reg, ev_idx_next;
    logic [31:0]     hdr_reg, hdr_next;
    logic [29:0]     n_reg, n_next;
    logic [SA_W-1:0] dst_reg, dst_next;
    logic [31:0]     res_reg, res_next;
    logic [29:0]     sd_reg, sd_next;
    logic [28:0]     flen_reg, flen_next;
    logic [28:0]     fk_reg, fk_next;
    logic [SA_W-1:0] faddr_reg, faddr_next;

    logic            h_we, h_re, r_we, r_re;
    logic [SA_W-1:0] h_waddr, h_raddr;
    logic [31:0]     h_wdata, h_rdata;
    logic [RS_W-1:0] r_waddr, r_raddr;
    logic [31:0]     r_wdata, r_rdata;

    logic        accept;
    logic [31:0] hacc;
    logic        hacc_ok;
    logic [12:0] rix13;
    logic        rix_ok;
    logic [31:0] from32, to32, ev_off;
    logic        range_bad, size_bad, rd_fwd, rd_tag3, trz, fits, gc_fault;
    logic [29:0] n_calc;
    logic [AI_W-1:0] k_inc, size_m1;
    logic [33:0] free34;

    shgc_ram #(.WIDTH(32), .DEPTH(2 * HEAP_WORDS)) u_heap (
        .clk     (clk),
        .wr_en   (h_we),
        .wr_addr (h_waddr),
        .wr_data (h_wdata),
        .rd_en   (h_re),
        .rd_addr (h_raddr),
        .rd_data (h_rdata)
    );

    shgc_ram #(.WIDTH(32), .DEPTH(ROOT_SLOTS)) u_root (
        .clk     (clk),
        .wr_en   (r_we),
        .wr_addr (r_waddr),
        .wr_data (r_wdata),
        .rd_en   (r_re),
        .rd_addr (r_raddr),
        .rd_data (r_rdata)
    );

    assign req_stall    = (state_reg != shgc_pkg::S_IDLE);
    assign accept       = req_valid && !req_stall;
    assign rsp_valid    = out_valid_reg;
    assign result_value = out_val_reg;
    assign status       = out_st_reg;
    assign collected    = out_col_reg;

    assign hacc    = 32'(node) - 32'd1 + 32'(offset);
    assign hacc_ok = (node != 14'd0) && (hacc < STORE32);
    assign rix13   = 13'(root_index);
    assign rix_ok  = rix13 < RS13;

    assign from32    = half_reg ? H32 : 32'd0;
    assign to32      = half_reg ? 32'd0 : H32;
    assign ev_off    = ev_idx_reg - from32;
    assign range_bad = (ev_idx_reg < from32) || (ev_off >= H32 - 32'd1);
    assign rd_fwd    = (h_rdata & shgc_pkg::FWD_BIT) != 32'd0;
    assign rd_tag3   = (h_rdata & shgc_pkg::TAG_MASK) == shgc_pkg::TAG_MASK;
    assign n_calc    = ((h_rdata & shgc_pkg::TAG_MASK) != shgc_pkg::TAG_TRACED) ? 30'd2 :
                       (h_rdata[28:0] == 29'd0) ? 30'd2 : 30'(h_rdata[28:0]) + 30'd1;
    assign size_bad  = (ev_off + 32'(n_reg) > H32) || (32'(copy_reg) + 32'(n_reg) > H32);
    assign trz       = ((hdr_reg & shgc_pkg::TAG_MASK) == shgc_pkg::TAG_TRACED)
                       && ((hdr_reg & shgc_pkg::LEN_MASK) == 32'd0);
    assign free34    = 34'(HEAP_WORDS) - 34'(alloc_reg);
    assign fits      = size_reg <= free34;
    assign k_inc     = k_reg + AI_W'(1);
    assign size_m1   = size_reg[AI_W-1:0] - AI_W'(1);
    assign gc_fault  = ((state_reg == shgc_pkg::E_CHK) && range_bad)
                    || ((state_reg == shgc_pkg::E_HDR) && !rd_fwd && rd_tag3)
                    || ((state_reg == shgc_pkg::E_SIZE) && size_bad)
                    || ((state_reg == shgc_pkg::G_SHDR) && rd_tag3);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shgc_pkg::S_CLEAR:
                if (ri_reg == RS13 - 13'd1) state_next = shgc_pkg::S_IDLE;
            shgc_pkg::S_IDLE:
                if (accept)
                begin
                    case (op)
                        shgc_pkg::OP_UNTRACED, shgc_pkg::OP_TAGGED,
                        shgc_pkg::OP_ARRAY, shgc_pkg::OP_STRING:
                            state_next = shgc_pkg::A_FIT;
                        shgc_pkg::OP_HEAP_RD:
                            state_next = hacc_ok ? shgc_pkg::S_HRD : shgc_pkg::S_DONE;
                        shgc_pkg::OP_ROOT_RD:
                            state_next = rix_ok ? shgc_pkg::S_RRD : shgc_pkg::S_DONE;
                        default:
                            state_next = shgc_pkg::S_DONE;
                    endcase
                end
            shgc_pkg::S_HRD, shgc_pkg::S_RRD:
                state_next = shgc_pkg::S_DONE;
            shgc_pkg::S_DONE:
                if (!out_valid_reg || !rsp_stall) state_next = shgc_pkg::S_IDLE;
            shgc_pkg::A_FIT:
                if (fits) state_next = shgc_pkg::A_FILL;
                else if (gc_done_reg) state_next = shgc_pkg::S_DONE;
                else state_next = shgc_pkg::G_START;
            shgc_pkg::A_FILL:
                if (k_reg == size_m1) state_next = shgc_pkg::S_DONE;
            shgc_pkg::G_START:
                state_next = (handler_reg != 32'd0) ? shgc_pkg::E_CHK : shgc_pkg::G_ROOT;
            shgc_pkg::G_ROOT:
                state_next = (ri_reg < live_reg) ? shgc_pkg::G_ROOTW : shgc_pkg::G_SCAN;
            shgc_pkg::G_ROOTW:
                state_next = (r_rdata == 32'd0) ? shgc_pkg::G_ROOT : shgc_pkg::E_CHK;
            shgc_pkg::G_SCAN:
                state_next = (scan_reg < copy_reg) ? shgc_pkg::G_SHDR : shgc_pkg::G_SWAP;
            shgc_pkg::G_SHDR:
                if (gc_fault) state_next = shgc_pkg::S_DONE;
                else if ((h_rdata & shgc_pkg::TAG_MASK) == shgc_pkg::TAG_TAGGED)
                    state_next = shgc_pkg::G_FLD;
                else if (((h_rdata & shgc_pkg::TAG_MASK) == shgc_pkg::TAG_TRACED)
                         && (h_rdata[28:0] != 29'd0))
                    state_next = shgc_pkg::G_FLD;
                else state_next = shgc_pkg::G_SCAN;
            shgc_pkg::G_FLD:
                state_next = (fk_reg < flen_reg) ? shgc_pkg::G_FLDW : shgc_pkg::G_SCAN;
            shgc_pkg::G_FLDW:
                state_next = (h_rdata == 32'd0) ? shgc_pkg::G_FLD : shgc_pkg::E_CHK;
            shgc_pkg::G_SWAP:
                state_next = shgc_pkg::A_FIT;
            shgc_pkg::E_CHK:
                state_next = gc_fault ? shgc_pkg::S_DONE : shgc_pkg::E_HDR;
            shgc_pkg::E_HDR:
                if (rd_fwd) state_next = shgc_pkg::E_FWDR;
                else if (gc_fault) state_next = shgc_pkg::S_DONE;
                else state_next = shgc_pkg::E_SIZE;
            shgc_pkg::E_FWDR:
                state_next = shgc_pkg::E_RET;
            shgc_pkg::E_SIZE:
                state_next = gc_fault ? shgc_pkg::S_DONE : shgc_pkg::E_CPRD;
            shgc_pkg::E_CPRD:
                state_next = shgc_pkg::E_CPWR;
            shgc_pkg::E_CPWR:
                if (k_inc == n_reg[AI_W-1:0]) state_next = shgc_pkg::E_FWD1;
            shgc_pkg::E_FWD1:
                state_next = shgc_pkg::E_FWD2;
            shgc_pkg::E_FWD2:
                state_next = shgc_pkg::E_RET;
            shgc_pkg::E_RET:
                state_next = (ctx_reg == shgc_pkg::CTX_FIELD) ? shgc_pkg::G_FLD
                                                              : shgc_pkg::G_ROOT;
            default:
                state_next = shgc_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        out_col_next   = out_col_reg;
        rs_val_next    = rs_val_reg;
        rs_st_next     = rs_st_reg;
        gc_done_next   = gc_done_reg;
        half_next      = half_reg;
        alloc_next     = alloc_reg;
        copy_next      = copy_reg;
        scan_next      = scan_reg;
        handler_next   = handler_reg;
        ri_next        = ri_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        live_next      = live_reg;
        size_next      = size_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        ptr_next       = ptr_reg;
        ev_idx_next    = ev_idx_reg;
        hdr_next       = hdr_reg;
        n_next         = n_reg;
        dst_next       = dst_reg;
        res_next       = res_reg;
        sd_next        = sd_reg;
        flen_next      = flen_reg;
        fk_next        = fk_reg;
        faddr_next     = faddr_reg;
        ctx_next       = ctx_reg;
        h_we    = 1'b0;
        h_waddr = '0;
        h_wdata = '0;
        h_re    = 1'b0;
        h_raddr = '0;
        r_we    = 1'b0;
        r_waddr = '0;
        r_wdata = '0;
        r_re    = 1'b0;
        r_raddr = '0;

        if (out_valid_reg && !rsp_stall) out_valid_next = 1'b0;

        if (gc_fault)
        begin
            copy_next   = '0;
            scan_next   = '0;
            rs_st_next  = shgc_pkg::STAT_CORRUPT;
        end

        unique case (state_reg)
            shgc_pkg::S_CLEAR:
            begin
                r_we    = 1'b1;
                r_waddr = ri_reg[RS_W-1:0];
                ri_next = ri_reg + 13'd1;
            end
            shgc_pkg::S_IDLE:
                if (accept)
                begin
                    rs_val_next  = '0;
                    rs_st_next   = shgc_pkg::STAT_OK;
                    gc_done_next = 1'b0;
                    op_next      = op;
                    value_next   = value;
                    live_next    = (13'(live_roots) > RS13) ? RS13 : 13'(live_roots);
                    case (op)
                        shgc_pkg::OP_ARRAY:
                            size_next = (value == 32'd0) ? 34'd2 : 34'(value) + 34'd1;
                        shgc_pkg::OP_STRING:
                            size_next = (value == 32'd0) ? 34'd2
                                      : 34'(value) + {1'b0, value, 1'b0} + 34'd1;
                        default:
                            size_next = 34'd2;
                    endcase
                    case (op)
                        shgc_pkg::OP_HEAP_RD:
                        begin
                            h_re    = hacc_ok;
                            h_raddr = hacc[SA_W-1:0];
                        end
                        shgc_pkg::OP_HEAP_WR:
                        begin
                            h_we    = hacc_ok;
                            h_waddr = hacc[SA_W-1:0];
                            h_wdata = value;
                        end
                        shgc_pkg::OP_ROOT_RD:
                        begin
                            r_re    = rix_ok;
                            r_raddr = rix13[RS_W-1:0];
                        end
                        shgc_pkg::OP_ROOT_WR:
                        begin
                            r_we    = rix_ok;
                            r_waddr = rix13[RS_W-1:0];
                            r_wdata = value;
                        end
                        shgc_pkg::OP_HDL_WR:
                            handler_next = value;
                        shgc_pkg::OP_HDL_RD:
                            rs_val_next = handler_reg;
                        default:
                        begin
                        end
                    endcase
                end
            shgc_pkg::S_HRD:
                rs_val_next = h_rdata;
            shgc_pkg::S_RRD:
                rs_val_next = r_rdata;
            shgc_pkg::S_DONE:
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = rs_val_reg;
                    out_st_next    = rs_st_reg;
                    out_col_next   = gc_done_reg;
                end
            shgc_pkg::A_FIT:
                if (fits)
                begin
                    p_next     = SA_W'(from32) + SA_W'(alloc_reg);
                    alloc_next = alloc_reg + size_reg[AI_W-1:0];
                    k_next     = '0;
                end
                else if (gc_done_reg)
                begin
                    rs_st_next = shgc_pkg::STAT_OOM;
                end
                else
                begin
                    gc_done_next = 1'b1;
                end
            shgc_pkg::A_FILL:
            begin
                h_we    = 1'b1;
                h_waddr = p_reg + SA_W'(k_reg);
                k_next  = k_inc;
                if (k_reg == '0)
                begin
                    ptr_next = 32'(p_reg) + value_reg + 32'd2;
                    case (op_reg)
                        shgc_pkg::OP_UNTRACED:
                            h_wdata = '0;
                        shgc_pkg::OP_TAGGED:
                            h_wdata = (value_reg & shgc_pkg::LEN_MASK) | shgc_pkg::TAG_TAGGED;
                        default:
                            h_wdata = (value_reg & shgc_pkg::LEN_MASK) | shgc_pkg::TAG_TRACED;
                    endcase
                end
                else if (op_reg == shgc_pkg::OP_UNTRACED)
                begin
                    h_wdata = value_reg;
                end
                else if ((op_reg == shgc_pkg::OP_STRING) && (32'(k_reg) <= value_reg))
                begin
                    h_wdata  = ptr_reg;
                    ptr_next = ptr_reg + 32'd2;
                end
                if (k_reg == size_m1) rs_val_next = 32'(p_reg) + 32'd1;
            end
            shgc_pkg::G_START:
            begin
                copy_next   = '0;
                scan_next   = '0;
                ri_next     = '0;
                ev_idx_next = handler_reg - 32'd1;
                ctx_next    = shgc_pkg::CTX_HANDLER;
            end
            shgc_pkg::G_ROOT:
            begin
                r_re    = ri_reg < live_reg;
                r_raddr = ri_reg[RS_W-1:0];
            end
            shgc_pkg::G_ROOTW:
            begin
                if (r_rdata == 32'd0) ri_next = ri_reg + 13'd1;
                ev_idx_next = r_rdata - 32'd1;
                ctx_next    = shgc_pkg::CTX_ROOT;
            end
            shgc_pkg::G_SCAN:
            begin
                h_re    = scan_reg < copy_reg;
                h_raddr = SA_W'(to32) + SA_W'(scan_reg);
            end
            shgc_pkg::G_SHDR:
            begin
                fk_next    = '0;
                faddr_next = SA_W'(to32) + SA_W'(scan_reg) + SA_W'(1);
                if ((h_rdata & shgc_pkg::TAG_MASK) == shgc_pkg::TAG_TAGGED)
                begin
                    flen_next = 29'd1;
                    sd_next   = 30'd2;
                end
                else if (((h_rdata & shgc_pkg::TAG_MASK) == shgc_pkg::TAG_TRACED)
                         && (h_rdata[28:0] != 29'd0))
                begin
                    flen_next = h_rdata[28:0];
                    sd_next   = 30'(h_rdata[28:0]) + 30'd1;
                end
                else if (!rd_tag3)
                begin
                    scan_next = scan_reg + AI_W'(2);
                end
            end
            shgc_pkg::G_FLD:
                if (fk_reg < flen_reg)
                begin
                    h_re    = 1'b1;
                    h_raddr = faddr_reg;
                end
                else
                begin
                    scan_next = scan_reg + sd_reg[AI_W-1:0];
                end
            shgc_pkg::G_FLDW:
            begin
                if (h_rdata == 32'd0)
                begin
                    faddr_next = faddr_reg + SA_W'(1);
                    fk_next    = fk_reg + 29'd1;
                end
                ev_idx_next = h_rdata - 32'd1;
                ctx_next    = shgc_pkg::CTX_FIELD;
            end
            shgc_pkg::G_SWAP:
            begin
                half_next  = !half_reg;
                alloc_next = copy_reg;
                copy_next  = '0;
                scan_next  = '0;
            end
            shgc_pkg::E_CHK:
            begin
                h_re    = !range_bad;
                h_raddr = ev_idx_reg[SA_W-1:0];
            end
            shgc_pkg::E_HDR:
            begin
                hdr_next = h_rdata;
                n_next   = n_calc;
                h_re     = rd_fwd;
                h_raddr  = ev_idx_reg[SA_W-1:0] + SA_W'(1);
            end
            shgc_pkg::E_FWDR:
                res_next = h_rdata;
            shgc_pkg::E_SIZE:
            begin
                dst_next = SA_W'(to32) + SA_W'(copy_reg);
                k_next   = '0;
            end
            shgc_pkg::E_CPRD:
            begin
                h_re    = 1'b1;
                h_raddr = ev_idx_reg[SA_W-1:0];
            end
            shgc_pkg::E_CPWR:
            begin
                h_we    = 1'b1;
                h_waddr = dst_reg + SA_W'(k_reg);
                h_wdata = (trz && (k_reg == AI_W'(1))) ? 32'd0 : h_rdata;
                h_re    = k_inc != n_reg[AI_W-1:0];
                h_raddr = ev_idx_reg[SA_W-1:0] + SA_W'(k_inc);
                k_next  = k_inc;
            end
            shgc_pkg::E_FWD1:
            begin
                h_we      = 1'b1;
                h_waddr   = ev_idx_reg[SA_W-1:0];
                h_wdata   = hdr_reg | shgc_pkg::FWD_BIT;
                copy_next = copy_reg + n_reg[AI_W-1:0];
            end
            shgc_pkg::E_FWD2:
            begin
                h_we     = 1'b1;
                h_waddr  = ev_idx_reg[SA_W-1:0] + SA_W'(1);
                h_wdata  = 32'(dst_reg) + 32'd1;
                res_next = 32'(dst_reg) + 32'd1;
            end
            shgc_pkg::E_RET:
                unique case (ctx_reg)
                    shgc_pkg::CTX_HANDLER:
                        handler_next = res_reg;
                    shgc_pkg::CTX_ROOT:
                    begin
                        r_we    = 1'b1;
                        r_waddr = ri_reg[RS_W-1:0];
                        r_wdata = res_reg;
                        ri_next = ri_reg + 13'd1;
                    end
                    default:
                    begin
                        h_we       = 1'b1;
                        h_waddr    = faddr_reg;
                        h_wdata    = res_reg;
                        faddr_next = faddr_reg + SA_W'(1);
                        fk_next    = fk_reg + 29'd1;
                    end
                endcase
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shgc_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
            alloc_reg     <= '0;
            copy_reg      <= '0;
            scan_reg      <= '0;
            handler_reg   <= '0;
            ri_reg        <= '0;
            gc_done_reg   <= 1'b0;
            ctx_reg       <= shgc_pkg::CTX_HANDLER;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
            alloc_reg     <= alloc_next;
            copy_reg      <= copy_next;
            scan_reg      <= scan_next;
            handler_reg   <= handler_next;
            ri_reg        <= ri_next;
            gc_done_reg   <= gc_done_next;
            ctx_reg       <= ctx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
        out_col_reg <= out_col_next;
        rs_val_reg  <= rs_val_next;
        rs_st_reg   <= rs_st_next;
        op_reg      <= op_next;
        value_reg   <= value_next;
        live_reg    <= live_next;
        size_reg    <= size_next;
        k_reg       <= k_next;
        p_reg       <= p_next;
        ptr_reg     <= ptr_next;
        ev_idx_reg  <= ev_idx_next;
        hdr_reg     <= hdr_next;
        n_reg       <= n_next;
        dst_reg     <= dst_next;
        res_reg     <= res_next;
        sd_reg      <= sd_next;
        flen_reg    <= flen_next;
        fk_reg      <= fk_next;
        faddr_reg   <= faddr_next;
    end

endmodule

>>> sim/tb_semispace_heap_copying_collector_unit.sv
// Self-checking testbench for semispace_heap_copying_collector_unit: directed and random
// allocations, heap/root/handler accesses and collections, checked by a heap scoreboard.
// Depends on shgc_pkg and the unit under test.
`timescale 1ns / 1ps

module tb_semispace_heap_copying_collector_unit;

    localparam int unsigned HEAP_W = 4096;
    localparam int unsigned ROOT_N = 2048;
    localparam int unsigned STORE_W = 2 * HEAP_W;
    localparam int unsigned PTR_ROOTS = 16;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_ITEMS = 950;
    localparam logic [3:0] OP_SPARE_LO = 4'd10;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [31:0] res;
        logic [1:0]  st;
        logic        col;
    } gc_rsp_t;

    class heap_scoreboard;
        bit [31:0] heap [STORE_W];
        bit        known [STORE_W];
        bit [31:0] roots [ROOT_N];
        bit [31:0] handler;
        bit        half;
        int unsigned alloc_idx, copy_idx, scan_pos;
        bit        fault;
        gc_rsp_t   pending [$];
        gc_rsp_t   last;
        int accepted, checked, mismatches, collections, oom_seen, corrupt_seen;

        function int unsigned span(bit [31:0] hdr);
            if ((hdr & shgc_pkg::TAG_MASK) != shgc_pkg::TAG_TRACED) return 2;
            return ((hdr & shgc_pkg::LEN_MASK) != 0) ? (hdr & shgc_pkg::LEN_MASK) + 1 : 2;
        endfunction

        function void put(int unsigned a, bit [31:0] v);
            heap[a] = v;
            known[a] = 1'b1;
        endfunction

        function bit [31:0] evacuate(bit [31:0] p);
            int unsigned from_b, to_b, idx, n, dst;
            bit [31:0] hdr;
            from_b = half ? HEAP_W : 0;
            to_b = half ? 0 : HEAP_W;
            if (p == 0 || fault) return p;
            idx = p - 1;
            if (idx < from_b || idx - from_b >= HEAP_W - 1)
            begin
                fault = 1'b1;
                return 0;
            end
            hdr = heap[idx];
            if (hdr[31]) return heap[idx + 1];
            if ((hdr & shgc_pkg::TAG_MASK) == shgc_pkg::TAG_MASK)
            begin
                fault = 1'b1;
                return 0;
            end
            n = span(hdr);
            if (idx - from_b + n > HEAP_W || copy_idx + n > HEAP_W)
            begin
                fault = 1'b1;
                return 0;
            end
            dst = to_b + copy_idx;
            for (int unsigned i = 0; i < n; i++) put(dst + i, heap[idx + i]);
            if ((hdr & shgc_pkg::TAG_MASK) == shgc_pkg::TAG_TRACED
                && (hdr & shgc_pkg::LEN_MASK) == 0)
                put(dst + 1, 0);
            copy_idx += n;
            put(idx, hdr | shgc_pkg::FWD_BIT);
            put(idx + 1, dst + 1);
            return dst + 1;
        endfunction

        function bit [31:0] forward(bit [31:0] w);
            bit [31:0] v;
            if (w == 0) return w;
            v = evacuate(w);
            return fault ? w : v;
        endfunction

        function bit collect(int unsigned live);
            int unsigned to_b, a, len, d;
            bit [31:0] hdr;
            to_b = half ? 0 : HEAP_W;
            fault = 1'b0;
            copy_idx = 0;
            scan_pos = 0;
            if (live > ROOT_N) live = ROOT_N;
            handler = forward(handler);
            for (int unsigned i = 0; i < live && !fault; i++) roots[i] = forward(roots[i]);
            while (!fault && scan_pos < copy_idx)
            begin
                a = to_b + scan_pos;
                hdr = heap[a];
                d = 2;
                case (hdr & shgc_pkg::TAG_MASK)
                    32'h0: d = 2;
                    shgc_pkg::TAG_TAGGED: heap[a + 1] = forward(heap[a + 1]);
                    shgc_pkg::TAG_TRACED:
                    begin
                        len = hdr & shgc_pkg::LEN_MASK;
                        for (int unsigned i = 0; i < len && !fault; i++)
                            heap[a + 1 + i] = forward(heap[a + 1 + i]);
                        d = (len != 0) ? len + 1 : 2;
                    end
                    default:
                    begin
                        fault = 1'b1;
                        d = 0;
                    end
                endcase
                scan_pos += d;
            end
            if (fault)
            begin
                copy_idx = 0;
                scan_pos = 0;
                return 1'b0;
            end
            half = ~half;
            alloc_idx = copy_idx;
            copy_idx = 0;
            scan_pos = 0;
            return 1'b1;
        endfunction

        function int unsigned alloc(longint unsigned size, int unsigned live,
                                    inout gc_rsp_t r);
            int unsigned idx;
            if (size > HEAP_W - alloc_idx)
            begin
                r.col = 1'b1;
                if (!collect(live))
                begin
                    r.st = shgc_pkg::STAT_CORRUPT;
                    return STORE_W;
                end
                if (size > HEAP_W - alloc_idx)
                begin
                    r.st = shgc_pkg::STAT_OOM;
                    return STORE_W;
                end
            end
            idx = (half ? HEAP_W : 0) + alloc_idx;
            alloc_idx += int'(size);
            return idx;
        endfunction

        function void note_request(logic [3:0] op, logic [31:0] value, logic [13:0] node,
                                   logic [12:0] offset, logic [10:0] ri, logic [11:0] live);
            gc_rsp_t r;
            longint unsigned size;
            int unsigned p, addr;
            r = '0;
            case (op)
                shgc_pkg::OP_UNTRACED, shgc_pkg::OP_TAGGED,
                shgc_pkg::OP_ARRAY, shgc_pkg::OP_STRING:
                begin
                    if (op == shgc_pkg::OP_ARRAY) size = value ? longint'(value) + 1 : 2;
                    else if (op == shgc_pkg::OP_STRING)
                        size = value ? 3 * longint'(value) + 1 : 2;
                    else size = 2;
                    p = alloc(size, live, r);
                    if (p < STORE_W)
                    begin
                        if (op == shgc_pkg::OP_UNTRACED)
                        begin
                            put(p, 0);
                            put(p + 1, value);
                        end
                        else
                        begin
                            put(p, (value & shgc_pkg::LEN_MASK) |
                                   (op == shgc_pkg::OP_TAGGED ? shgc_pkg::TAG_TAGGED
                                                              : shgc_pkg::TAG_TRACED));
                            put(p + 1, 0);
                            if (op != shgc_pkg::OP_TAGGED)
                                for (int unsigned i = 0; i < value; i++)
                                begin
                                    if (op == shgc_pkg::OP_ARRAY) put(p + 1 + i, 0);
                                    else
                                    begin
                                        addr = p + value + 1 + 2 * i;
                                        put(addr, 0);
                                        put(addr + 1, 0);
                                        put(p + 1 + i, addr + 1);
                                    end
                                end
                        end
                        r.res = p + 1;
                    end
                end
                shgc_pkg::OP_HEAP_RD, shgc_pkg::OP_HEAP_WR:
                begin
                    addr = node - 1 + offset;
                    if (node != 0 && addr < STORE_W)
                    begin
                        if (op == shgc_pkg::OP_HEAP_RD) r.res = heap[addr];
                        else put(addr, value);
                    end
                end
                shgc_pkg::OP_ROOT_RD: r.res = roots[ri];
                shgc_pkg::OP_ROOT_WR: roots[ri] = value;
                shgc_pkg::OP_HDL_WR: handler = value;
                shgc_pkg::OP_HDL_RD: r.res = handler;
                default: ;
            endcase
            if (r.col) collections++;
            if (r.st == shgc_pkg::STAT_OOM) oom_seen++;
            if (r.st == shgc_pkg::STAT_CORRUPT) corrupt_seen++;
            pending.push_back(r);
            last = r;
            accepted++;
        endfunction

        function void check(logic [31:0] res, logic [1:0] st, logic col);
            gc_rsp_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value=%h status=%0d collected=%0b", res, st, col);
                return;
            end
            e = pending.pop_front();
            if (res !== e.res || st !== e.st || col !== e.col)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: exp value=%h status=%0d collected=%0b, got %h %0d %0b",
                             checked, e.res, e.st, e.col, res, st, col);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [3:0]  op;
    logic [31:0] value;
    logic [13:0] node;
    logic [12:0] offset;
    logic [10:0] root_index;
    logic [11:0] live_roots;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [31:0] result_value;
    logic [1:0]  status;
    logic        collected;

    heap_scoreboard sb = new();
    int cycles = 0;
    int burst_left = 0;
    bit holdoff_done = 0;

    semispace_heap_copying_collector_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .op(op), .value(value), .node(node), .offset(offset),
        .root_index(root_index), .live_roots(live_roots),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .result_value(result_value), .status(status), .collected(collected)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending.size());
            $display("tb_semispace_heap_copying_collector_unit: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall) sb.check(result_value, status, collected);
    end

    // receiver stall pattern, with one long hold-off
    initial
    begin
        int mode, mode_left;
        mode = 0;
        mode_left = 50;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!holdoff_done && sb.accepted >= 400)
            begin
                holdoff_done = 1;
                rsp_stall <= 1'b1;
                repeat (300) @(negedge clk);
            end
            case (mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 99) < 30);
                2: rsp_stall <= ~rsp_stall;
                default: rsp_stall <= ($urandom_range(0, 99) < 80);
            endcase
            mode_left--;
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 200);
            end
        end
    end

    task automatic send(input logic [3:0] o, input logic [31:0] v, input logic [13:0] n,
                        input logic [12:0] off, input logic [10:0] ri, input logic [11:0] lv);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        req_valid <= 1'b1;
        op <= o;
        value <= v;
        node <= n;
        offset <= off;
        root_index <= ri;
        live_roots <= lv;
        do @(posedge clk); while (req_stall);
        sb.note_request(o, v, n, off, ri, lv);
        burst_left--;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_ptr();
        logic [31:0] cand [$];
        for (int i = 0; i < PTR_ROOTS; i++) if (sb.roots[i] != 0) cand.push_back(sb.roots[i]);
        if (sb.handler != 0) cand.push_back(sb.handler);
        if (cand.size() == 0 || $urandom_range(0, 5) == 0) return 0;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    task automatic scrub();
        for (int i = 0; i < PTR_ROOTS; i++)
            if (sb.roots[i] != 0) send(shgc_pkg::OP_ROOT_WR, 0, 0, 0, i, 0);
        if (sb.handler != 0) send(shgc_pkg::OP_HDL_WR, 0, 0, 0, 0, 0);
    endtask

    task automatic after_step(input logic [11:0] lv);
        if (sb.last.st != shgc_pkg::STAT_OK || (sb.last.col && sb.alloc_idx > 1500)) scrub();
        else if (sb.last.col && lv < PTR_ROOTS)
            for (int i = lv; i < PTR_ROOTS; i++)
                if (sb.roots[i] != 0) send(shgc_pkg::OP_ROOT_WR, 0, 0, 0, i, 0);
    endtask

    task automatic directed();
        logic [31:0] p;
        send(shgc_pkg::OP_ROOT_RD, 0, 0, 0, 0, 0);
        send(shgc_pkg::OP_ROOT_RD, 0, 0, 0, 11'd2047, 0);
        send(shgc_pkg::OP_HDL_RD, 0, 0, 0, 0, 0);
        send(OP_SPARE_HI, 32'hffff_ffff, 14'h3fff, 13'h1fff, 11'h7ff, 12'hfff);
        send(shgc_pkg::OP_HEAP_RD, 0, 0, 5, 0, 0);
        send(shgc_pkg::OP_HEAP_WR, 32'hffff_ffff, 14'h3fff, 13'h1fff, 0, 0);
        send(shgc_pkg::OP_UNTRACED, 32'hffff_ffff, 0, 0, 0, 0);
        send(shgc_pkg::OP_ROOT_WR, sb.last.res, 0, 0, 0, 0);
        send(shgc_pkg::OP_TAGGED, 32'hffff_ffff, 0, 0, 0, 0);
        send(shgc_pkg::OP_ROOT_WR, sb.last.res, 0, 0, 1, 0);
        send(shgc_pkg::OP_ARRAY, 0, 0, 0, 0, 0);
        send(shgc_pkg::OP_ARRAY, 3, 0, 0, 0, 0);
        send(shgc_pkg::OP_ROOT_WR, sb.last.res, 0, 0, 2, 0);
        send(shgc_pkg::OP_STRING, 0, 0, 0, 0, 0);
        send(shgc_pkg::OP_STRING, 2, 0, 0, 0, 0);
        p = sb.last.res;
        send(shgc_pkg::OP_HDL_WR, p, 0, 0, 0, 0);
        send(shgc_pkg::OP_HEAP_RD, 0, p, 2, 0, 0);
        send(shgc_pkg::OP_HEAP_WR, sb.roots[0], sb.roots[1], 1, 0, 0);
        // request larger than the heap: collect, still full
        send(shgc_pkg::OP_ARRAY, 32'hffff_ffff, 0, 0, 0, 12'hfff);
        after_step(12'hfff);
        send(shgc_pkg::OP_ARRAY, 4095, 0, 0, 0, 0);
        send(shgc_pkg::OP_UNTRACED, 0, 0, 0, 0, 0);
        // tag 3 header reached during collection
        send(shgc_pkg::OP_TAGGED, 7, 0, 0, 0, 0);
        p = sb.last.res;
        send(shgc_pkg::OP_ROOT_WR, p, 0, 0, 0, 0);
        send(shgc_pkg::OP_HEAP_WR, sb.heap[p - 1] | shgc_pkg::TAG_MASK, p, 0, 0, 0);
        send(shgc_pkg::OP_STRING, 1365, 0, 0, 0, 16);
        after_step(16);
        // root outside the active half
        send(shgc_pkg::OP_ROOT_WR, 32'hffff_ffff, 0, 0, 3, 0);
        send(shgc_pkg::OP_ARRAY, 4095, 0, 0, 0, 12'd2048);
        after_step(12'd2048);
        // node length running past the end of the half
        send(shgc_pkg::OP_UNTRACED, 1, 0, 0, 0, 0);
        p = sb.last.res;
        send(shgc_pkg::OP_ROOT_WR, p, 0, 0, 0, 0);
        send(shgc_pkg::OP_HEAP_WR, shgc_pkg::TAG_TRACED | 32'd5000, p, 0, 0, 0);
        send(shgc_pkg::OP_ARRAY, 4095, 0, 0, 0, 1);
        after_step(1);
    endtask

    task automatic random_item();
        int r, s;
        logic [31:0] p, v, hdr, prev;
        logic [11:0] lv;
        logic [13:0] n;
        logic [12:0] off;
        int unsigned len;
        r = $urandom_range(0, 99);
        lv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(16, 4095);
        if (r < 40)
        begin
            if (r < 12) v = $urandom;
            else if (r < 20) v = $urandom;
            else if (r < 32)
            begin
                s = $urandom_range(0, 99);
                v = (s < 70) ? $urandom_range(0, 15)
                  : (s < 99) ? $urandom_range(16, 300) : $urandom;
            end
            else
            begin
                s = $urandom_range(0, 99);
                v = (s < 80) ? $urandom_range(0, 10)
                  : (s < 99) ? $urandom_range(11, 300) : $urandom;
            end
            send(r < 12 ? shgc_pkg::OP_UNTRACED : r < 20 ? shgc_pkg::OP_TAGGED
                 : r < 32 ? shgc_pkg::OP_ARRAY : shgc_pkg::OP_STRING,
                 v, $urandom, $urandom, $urandom, lv);
            after_step(lv);
            if (sb.last.st == shgc_pkg::STAT_OK && $urandom_range(0, 1) == 0)
                send(shgc_pkg::OP_ROOT_WR, sb.last.res, 0, 0,
                     $urandom_range(0, PTR_ROOTS - 1), 0);
            else if (sb.last.st == shgc_pkg::STAT_OK && $urandom_range(0, 4) == 0)
                send(shgc_pkg::OP_HDL_WR, sb.last.res, 0, 0, 0, 0);
        end
        else if (r < 62)
        begin
            p = pick_ptr();
            if (p == 0 || $urandom_range(0, 4) == 0)
            begin
                n = $urandom;
                off = $urandom;
                if (n != 0 && n - 1 + off < STORE_W && (r >= 52 || !sb.known[n - 1 + off]))
                    n = 0;
                send(r < 52 ? shgc_pkg::OP_HEAP_RD : shgc_pkg::OP_HEAP_WR,
                     $urandom, n, off, $urandom, lv);
            end
            else
            begin
                hdr = sb.heap[p - 1];
                len = hdr & shgc_pkg::LEN_MASK;
                if (r < 52)
                    send(shgc_pkg::OP_HEAP_RD, $urandom, p,
                         $urandom_range(0, sb.span(hdr) - 1), 0, 0);
                else if ((hdr & shgc_pkg::TAG_MASK) == shgc_pkg::TAG_TAGGED)
                    send(shgc_pkg::OP_HEAP_WR, pick_ptr(), p, 1, 0, 0);
                else if ((hdr & shgc_pkg::TAG_MASK) == shgc_pkg::TAG_TRACED && len != 0)
                    send(shgc_pkg::OP_HEAP_WR, pick_ptr(), p, $urandom_range(1, len), 0, 0);
                else send(shgc_pkg::OP_HEAP_WR, $urandom, p, 1, 0, 0);
            end
        end
        else if (r < 70)
        begin
            send(shgc_pkg::OP_ROOT_RD, $urandom, $urandom, $urandom, $urandom, lv);
        end
        else if (r < 78)
        begin
            send(shgc_pkg::OP_ROOT_WR, pick_ptr(), 0, 0, $urandom_range(0, PTR_ROOTS - 1), lv);
        end
        else if (r < 82)
        begin
            s = $urandom_range(0, ROOT_N - 1);
            prev = sb.roots[s];
            send(shgc_pkg::OP_ROOT_WR, $urandom, 0, 0, s, 0);
            send(shgc_pkg::OP_ROOT_RD, 0, 0, 0, s, 0);
            send(shgc_pkg::OP_ROOT_WR, prev, 0, 0, s, 0);
        end
        else if (r < 86)
        begin
            send(shgc_pkg::OP_HDL_WR, pick_ptr(), 0, 0, 0, 0);
        end
        else if (r < 89)
        begin
            send(shgc_pkg::OP_HDL_RD, $urandom, $urandom, $urandom, $urandom, lv);
        end
        else if (r < 91)
        begin
            prev = sb.handler;
            send(shgc_pkg::OP_HDL_WR, $urandom, 0, 0, 0, 0);
            send(shgc_pkg::OP_HDL_RD, 0, 0, 0, 0, 0);
            send(shgc_pkg::OP_HDL_WR, prev, 0, 0, 0, 0);
        end
        else if (r < 94)
        begin
            send($urandom_range(OP_SPARE_LO, OP_SPARE_HI), $urandom, $urandom, $urandom,
                 $urandom, $urandom);
        end
        else if (r < 95)
        begin
            p = pick_ptr();
            if (p != 0)
                send(shgc_pkg::OP_HEAP_WR, sb.heap[p - 1] | shgc_pkg::TAG_MASK, p, 0, 0, 0);
        end
        else
        begin
            send(shgc_pkg::OP_ROOT_RD, 0, 0, 0, $urandom_range(0, PTR_ROOTS - 1), 0);
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        req_valid = 1'b0;
        op = '0;
        value = '0;
        node = '0;
        offset = '0;
        root_index = '0;
        live_roots = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        directed();
        while (sb.accepted < RANDOM_ITEMS) random_item();
        req_valid <= 1'b0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        $display("%0d transactions, %0d results checked, %0d collections",
                 sb.accepted, sb.checked, sb.collections);
        $display("%0d out of memory, %0d corrupt, %0d mismatches, %0d results never seen",
                 sb.oom_seen, sb.corrupt_seen, sb.mismatches, sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_semispace_heap_copying_collector_unit: PASS");
        else
            $display("tb_semispace_heap_copying_collector_unit: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
sv/shgc_pkg.sv
sv/shgc_ram.sv
sv/semispace_heap_copying_collector_unit.sv
sim/tb_semispace_heap_copying_collector_unit.sv
